[rtl/core/hcaf_pkg.sv]
`timescale 1ns / 1ps

package hcaf_pkg;

  localparam int unsigned CmdWidth  = 6;
  localparam int unsigned WordWidth = 16;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned BitIdxW   = 3;

  // decimal adjust constants
  localparam logic [7:0] DaaHiAdj = 8'h60;
  localparam logic [7:0] DaaLoAdj = 8'h06;
  localparam logic [7:0] DaaLimit = 8'h99;
  localparam logic [3:0] DaaDigit = 4'h9;

  typedef enum logic [CmdWidth-1:0] {
    CMD_ADD   = 6'd0,
    CMD_ADC   = 6'd1,
    CMD_SUB   = 6'd2,
    CMD_SBC   = 6'd3,
    CMD_AND   = 6'd4,
    CMD_XOR   = 6'd5,
    CMD_OR    = 6'd6,
    CMD_CP    = 6'd7,
    CMD_INC   = 6'd8,
    CMD_DEC   = 6'd9,
    CMD_DAA   = 6'd10,
    CMD_CPL   = 6'd11,
    CMD_SCF   = 6'd12,
    CMD_CCF   = 6'd13,
    CMD_RLC   = 6'd14,
    CMD_RRC   = 6'd15,
    CMD_RL    = 6'd16,
    CMD_RR    = 6'd17,
    CMD_SLA   = 6'd18,
    CMD_SRA   = 6'd19,
    CMD_SRL   = 6'd20,
    CMD_SWAP  = 6'd21,
    CMD_BIT   = 6'd22,
    CMD_RES   = 6'd23,
    CMD_SET   = 6'd24,
    CMD_RLCA  = 6'd25,
    CMD_RRCA  = 6'd26,
    CMD_RLA   = 6'd27,
    CMD_RRA   = 6'd28,
    CMD_ADD16 = 6'd29,
    CMD_SPE8  = 6'd30,
    CMD_INC16 = 6'd31,
    CMD_DEC16 = 6'd32
  } alu_cmd_e;

  typedef struct packed {
    logic [CmdWidth-1:0]  cmd;
    logic [WordWidth-1:0] operand_a;
    logic [WordWidth-1:0] operand_b;
    logic [BitIdxW-1:0]   bit_index;
    logic                 zero_in;
    logic                 subtract_in;
    logic                 half_in;
    logic                 carry_in;
  } alu_req_t;

  typedef struct packed {
    logic [WordWidth-1:0] result;
    logic                 zero_out;
    logic                 subtract_out;
    logic                 half_out;
    logic                 carry_out;
  } alu_rsp_t;

endpackage

[rtl/core/hcaf_if.sv]
`timescale 1ns / 1ps

interface hcaf_req_if import hcaf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CmdWidth-1:0]  cmd;
  logic [WordWidth-1:0] operand_a;
  logic [WordWidth-1:0] operand_b;
  logic [BitIdxW-1:0]   bit_index;
  logic                 zero_in;
  logic                 subtract_in;
  logic                 half_in;
  logic                 carry_in;

  modport source (
    output valid, cmd, operand_a, operand_b, bit_index,
           zero_in, subtract_in, half_in, carry_in,
    input  ready
  );

  modport sink (
    input  valid, cmd, operand_a, operand_b, bit_index,
           zero_in, subtract_in, half_in, carry_in,
    output ready
  );
endinterface

interface hcaf_rsp_if import hcaf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WordWidth-1:0] result;
  logic                 zero_out;
  logic                 subtract_out;
  logic                 half_out;
  logic                 carry_out;

  modport source (
    output valid, result, zero_out, subtract_out, half_out, carry_out,
    input  ready
  );

  modport sink (
    input  valid, result, zero_out, subtract_out, half_out, carry_out,
    output ready
  );
endinterface

[rtl/core/hcaf_alu.sv]
`timescale 1ns / 1ps

module hcaf_alu import hcaf_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] a16;
  logic [15:0] b16;
  logic [7:0]  mask;
  logic        ci_add;
  logic        ci_sub;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_half;
  logic [16:0] w_sum;
  logic [12:0] w_half;
  logic [15:0] sp_sum;
  logic [4:0]  sp_half;
  logic [8:0]  sp_byte;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_val;
  logic [7:0]  r8;
  logic [15:0] r16;
  logic        wide;
  logic        z;
  logic        n;
  logic        h;
  logic        c;

  assign a   = req_i.operand_a[7:0];
  assign b   = req_i.operand_b[7:0];
  assign a16 = req_i.operand_a;
  assign b16 = req_i.operand_b;

  assign mask = 8'd1 << req_i.bit_index;

  // adc and sbc take the incoming carry, plain add, sub and cp do not
  assign ci_add = (req_i.cmd == CMD_ADC) & req_i.carry_in;
  assign ci_sub = (req_i.cmd == CMD_SBC) & req_i.carry_in;

  assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, ci_add};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci_add};
  assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, ci_sub};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci_sub};

  assign w_sum   = {1'b0, a16} + {1'b0, b16};
  assign w_half  = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
  assign sp_sum  = a16 + {{8{b[7]}}, b};
  assign sp_half = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
  assign sp_byte = {1'b0, a16[7:0]} + {1'b0, b};

  // decimal adjust, direction set by the incoming subtract flag
  always_comb begin
    daa_hi = req_i.carry_in | (a > DaaLimit);
    daa_lo = req_i.half_in | (a[3:0] > DaaDigit);
    if (req_i.subtract_in) begin
      daa_val = a - (req_i.carry_in ? DaaHiAdj : 8'h00)
                  - (req_i.half_in ? DaaLoAdj : 8'h00);
    end else begin
      daa_val = a + (daa_hi ? DaaHiAdj : 8'h00) + (daa_lo ? DaaLoAdj : 8'h00);
    end
  end

  always_comb begin
    r8   = a;
    r16  = a16;
    wide = 1'b0;
    z    = req_i.zero_in;
    n    = req_i.subtract_in;
    h    = req_i.half_in;
    c    = req_i.carry_in;
    unique case (req_i.cmd)
      CMD_ADD, CMD_ADC: begin
        r8 = add_sum[7:0];
        z  = (add_sum[7:0] == 8'h00);
        n  = 1'b0;
        h  = add_half[4];
        c  = add_sum[8];
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        if (req_i.cmd != CMD_CP) begin
          r8 = sub_diff[7:0];
        end
        z = (sub_diff[7:0] == 8'h00);
        n = 1'b1;
        h = sub_half[4];
        c = sub_diff[8];
      end
      CMD_AND: begin
        r8 = a & b;
        z  = ((a & b) == 8'h00);
        n  = 1'b0;
        h  = 1'b1;
        c  = 1'b0;
      end
      CMD_XOR: begin
        r8 = a ^ b;
        z  = ((a ^ b) == 8'h00);
        n  = 1'b0;
        h  = 1'b0;
        c  = 1'b0;
      end
      CMD_OR: begin
        r8 = a | b;
        z  = ((a | b) == 8'h00);
        n  = 1'b0;
        h  = 1'b0;
        c  = 1'b0;
      end
      CMD_INC: begin
        r8 = a + 8'd1;
        z  = (a == 8'hFF);
        n  = 1'b0;
        h  = (a[3:0] == 4'hF);
      end
      CMD_DEC: begin
        r8 = a - 8'd1;
        z  = (a == 8'h01);
        n  = 1'b1;
        h  = (a[3:0] == 4'h0);
      end
      CMD_DAA: begin
        r8 = daa_val;
        z  = (daa_val == 8'h00);
        h  = 1'b0;
        if (!req_i.subtract_in) begin
          c = daa_hi;
        end
      end
      CMD_CPL: begin
        r8 = ~a;
        n  = 1'b1;
        h  = 1'b1;
      end
      CMD_SCF: begin
        n = 1'b0;
        h = 1'b0;
        c = 1'b1;
      end
      CMD_CCF: begin
        n = 1'b0;
        h = 1'b0;
        c = ~req_i.carry_in;
      end
      CMD_RLC, CMD_RLCA: begin
        r8 = {a[6:0], a[7]};
        c  = a[7];
        n  = 1'b0;
        h  = 1'b0;
        z  = (req_i.cmd == CMD_RLC) && (a == 8'h00);
      end
      CMD_RRC, CMD_RRCA: begin
        r8 = {a[0], a[7:1]};
        c  = a[0];
        n  = 1'b0;
        h  = 1'b0;
        z  = (req_i.cmd == CMD_RRC) && (a == 8'h00);
      end
      CMD_RL, CMD_RLA: begin
        r8 = {a[6:0], req_i.carry_in};
        c  = a[7];
        n  = 1'b0;
        h  = 1'b0;
        z  = (req_i.cmd == CMD_RL) && ({a[6:0], req_i.carry_in} == 8'h00);
      end
      CMD_RR, CMD_RRA: begin
        r8 = {req_i.carry_in, a[7:1]};
        c  = a[0];
        n  = 1'b0;
        h  = 1'b0;
        z  = (req_i.cmd == CMD_RR) && ({req_i.carry_in, a[7:1]} == 8'h00);
      end
      CMD_SLA: begin
        r8 = {a[6:0], 1'b0};
        c  = a[7];
        n  = 1'b0;
        h  = 1'b0;
        z  = (a[6:0] == 7'h00);
      end
      CMD_SRA: begin
        r8 = {a[7], a[7:1]};
        c  = a[0];
        n  = 1'b0;
        h  = 1'b0;
        z  = (a[7:1] == 7'h00);
      end
      CMD_SRL: begin
        r8 = {1'b0, a[7:1]};
        c  = a[0];
        n  = 1'b0;
        h  = 1'b0;
        z  = (a[7:1] == 7'h00);
      end
      CMD_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        c  = 1'b0;
        n  = 1'b0;
        h  = 1'b0;
        z  = (a == 8'h00);
      end
      CMD_BIT: begin
        z = ((a & mask) == 8'h00);
        n = 1'b0;
        h = 1'b1;
      end
      CMD_RES: r8 = a & ~mask;
      CMD_SET: r8 = a | mask;
      CMD_ADD16: begin
        wide = 1'b1;
        r16  = w_sum[15:0];
        n    = 1'b0;
        h    = w_half[12];
        c    = w_sum[16];
      end
      CMD_SPE8: begin
        wide = 1'b1;
        r16  = sp_sum;
        z    = 1'b0;
        n    = 1'b0;
        h    = sp_half[4];
        c    = sp_byte[8];
      end
      CMD_INC16: begin
        wide = 1'b1;
        r16  = a16 + 16'd1;
      end
      CMD_DEC16: begin
        wide = 1'b1;
        r16  = a16 - 16'd1;
      end
      // unused codes pass the operand and flags straight through
      default: wide = 1'b1;
    endcase
  end

  assign rsp_o.result       = wide ? r16 : {8'h00, r8};
  assign rsp_o.zero_out     = z;
  assign rsp_o.subtract_out = n;
  assign rsp_o.half_out     = h;
  assign rsp_o.carry_out    = c;

endmodule

[rtl/core/handheld_cpu_alu_flags_core.sv]
`timescale 1ns / 1ps

// ALU and flag unit of an 8-bit handheld CPU: one operation code, two
// operands, a bit index and the incoming Z, N, H, C flags go in, the result
// and the updated flags come out. Every operation is combinational logic
// between the input register and the result register, so a transfer can be
// accepted on every clock while the pipeline is not stalled; an accepted
// transfer is held in the input register and then in the result register.
// A stalled result only holds the pipeline while both registers are full.
// 8-bit operations return zero in the upper result byte; unused operation
// codes return operand_a with the flags unchanged.
module handheld_cpu_alu_flags_core import hcaf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  hcaf_req_if.sink   req_i,
  hcaf_rsp_if.source rsp_o
);

  alu_req_t s1_d;
  alu_req_t s1_q;
  logic     s1_valid_q;
  alu_rsp_t alu_rsp;
  alu_rsp_t out_q;
  logic     out_valid_q;
  logic     s1_ready;

  // the input stage moves on when the result register is empty or being taken
  assign s1_ready    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || s1_ready;

  assign s1_d.cmd         = req_i.cmd;
  assign s1_d.operand_a   = req_i.operand_a;
  assign s1_d.operand_b   = req_i.operand_b;
  assign s1_d.bit_index   = req_i.bit_index;
  assign s1_d.zero_in     = req_i.zero_in;
  assign s1_d.subtract_in = req_i.subtract_in;
  assign s1_d.half_in     = req_i.half_in;
  assign s1_d.carry_in    = req_i.carry_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (s1_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_q <= s1_d;
    end
    if (s1_valid_q && s1_ready) begin
      out_q <= alu_rsp;
    end
  end

  hcaf_alu u_alu (
    .req_i (s1_q),
    .rsp_o (alu_rsp)
  );

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result       = out_q.result;
  assign rsp_o.zero_out     = out_q.zero_out;
  assign rsp_o.subtract_out = out_q.subtract_out;
  assign rsp_o.half_out     = out_q.half_out;
  assign rsp_o.carry_out    = out_q.carry_out;

  a_accept_loads_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> s1_valid_q)
    else $error("accepted transfer did not reach the input register");

  a_ready_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (!s1_valid_q || !out_valid_q || rsp_o.ready))
    else $error("input ready while both stages are full and stalled");

  a_stage_moves_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_ready |=> out_valid_q)
    else $error("input register advanced without filling the result register");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.ready && !s1_valid_q |=> !out_valid_q)
    else $error("result register still valid after its transfer");

  a_byte_ops_high_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_ready && (s1_q.cmd <= CMD_RRA) |=> (out_q.result[15:8] == 8'h00))
    else $error("8-bit operation left a non-zero upper result byte");

endmodule
